>>> hdl/assert_macros.svh
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHM_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHM_ASSERT(label, clk, rst_n, prop, msg)
`define CHM_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> hdl/chm_pkg.sv
// Package with the request and status codes of the hash map.
package chm_pkg;
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FORCE  = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_DELETE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 9;
endpackage

>>> hdl/chm_fifo.sv
// Small queue that decouples two sides of the hash map.
module chm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

>>> hdl/chm_engine.sv
// Back part of the hash map: chain walks, lookups, updates, deletes, appends and compaction.
module chm_engine #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  chm_pkg::t_req         i_req_type,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_req_ready,
    output logic                  o_res_valid,
    output chm_pkg::t_status      o_status,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [chm_pkg::LIVE_W-1:0] o_live,
    input  logic                  i_res_ready
);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = IW + 1;
    localparam logic [PW-1:0] EMPTY = PW'(CAPACITY);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_HEAD    = 11'b00000000100,
        S_HEADW   = 11'b00000001000,
        S_ENTRY   = 11'b00000010000,
        S_CHECK   = 11'b00000100000,
        S_APPEND  = 11'b00001000000,
        S_CPCLR   = 11'b00010000000,
        S_CPREAD  = 11'b00100000000,
        S_CPWAIT  = 11'b01000000000,
        S_CPHEAD  = 11'b10000000000
    } t_state;

    // Memories.
    logic [PW-1:0]         r_head_mem [CAPACITY];
    logic [KEY_BITS-1:0]   r_key_mem  [CAPACITY];
    logic [VALUE_BITS-1:0] r_val_mem  [CAPACITY];
    logic [PW-1:0]         r_link_mem [CAPACITY];
    logic [CAPACITY-1:0]   r_live;

    t_state                r_state;
    chm_pkg::t_req         r_req;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [PW-1:0]         r_cur;
    logic [PW-1:0]         r_prev;
    logic [PW-1:0]         r_steps;
    logic [PW-1:0]         r_append;
    logic [PW-1:0]         r_count;
    logic [PW-1:0]         r_rd;
    logic [PW-1:0]         r_wr;
    logic [PW-1:0]         r_head_q;
    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;
    logic [PW-1:0]         r_link_q;
    logic                  r_res_valid;
    chm_pkg::t_status      r_status;
    logic [VALUE_BITS-1:0] r_vout;
    logic [IW-1:0]         w_bucket;
    logic [IW-1:0]         w_cpbucket;

    assign w_bucket    = r_key[IW-1:0];
    assign w_cpbucket  = r_key_q[IW-1:0];
    // A new request may start in the cycle the held result leaves.
    assign o_req_ready = (r_state == S_IDLE) && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_status    = r_status;
    assign o_value     = r_vout;
    assign o_live      = chm_pkg::LIVE_W'(r_count);

    // Main sequencer: one memory access per port per cycle, reads registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rd        <= '0;
            r_append    <= '0;
            r_count     <= '0;
            r_live      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_head_mem[r_rd[IW-1:0]] <= EMPTY;
                    if (r_rd == PW'(CAPACITY-1)) begin
                        r_state <= S_IDLE;
                    end
                    r_rd <= r_rd + 1'b1;
                end
                S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        r_req   <= i_req_type;
                        r_key   <= i_key;
                        r_value <= i_value;
                        r_prev  <= EMPTY;
                        r_steps <= '0;
                        r_state <= (i_req_type == chm_pkg::REQ_FORCE) ? S_CHECK : S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_head_q <= r_head_mem[w_bucket];
                    r_state  <= S_HEADW;
                end
                S_HEADW: begin
                    r_cur   <= r_head_q;
                    r_state <= S_ENTRY;
                end
                S_ENTRY: begin
                    // Stop when the walk leaves the written area or has taken CAPACITY steps.
                    if (r_cur >= r_append || r_steps == PW'(CAPACITY)) begin
                        r_cur <= EMPTY;
                        if (r_req == chm_pkg::REQ_INSERT) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_status    <= chm_pkg::ST_NOT_FOUND;
                            r_vout      <= '0;
                            r_res_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_key_q  <= r_key_mem[r_cur[IW-1:0]];
                        r_val_q  <= r_val_mem[r_cur[IW-1:0]];
                        r_link_q <= r_link_mem[r_cur[IW-1:0]];
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_req == chm_pkg::REQ_FORCE || r_cur == EMPTY) begin
                        // Append path, with compaction when exhausted and a full result when no holes are left.
                        if (r_append == PW'(CAPACITY)) begin
                            if (r_count == PW'(CAPACITY)) begin
                                r_status    <= chm_pkg::ST_FULL;
                                r_vout      <= '0;
                                r_res_valid <= 1'b1;
                                r_state     <= S_IDLE;
                            end else begin
                                r_rd    <= '0;
                                r_state <= S_CPCLR;
                            end
                        end else begin
                            r_head_q <= r_head_mem[w_bucket];
                            r_state  <= S_APPEND;
                        end
                    end else if (r_key_q == r_key) begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        case (r_req)
                            chm_pkg::REQ_INSERT: begin
                                r_val_mem[r_cur[IW-1:0]] <= r_value;
                                r_vout   <= '0;
                                r_status <= chm_pkg::ST_UPDATED;
                            end
                            chm_pkg::REQ_LOOKUP: begin
                                r_vout   <= r_val_q;
                                r_status <= chm_pkg::ST_FOUND;
                            end
                            default: begin
                                if (r_prev == EMPTY) begin
                                    r_head_mem[w_bucket] <= r_link_q;
                                end else begin
                                    r_link_mem[r_prev[IW-1:0]] <= r_link_q;
                                end
                                r_live[r_cur[IW-1:0]] <= 1'b0;
                                r_count  <= r_count - 1'b1;
                                r_vout   <= '0;
                                r_status <= chm_pkg::ST_DELETED;
                            end
                        endcase
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_link_q;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_ENTRY;
                    end
                end
                S_APPEND: begin
                    r_key_mem[r_append[IW-1:0]]  <= r_key;
                    r_val_mem[r_append[IW-1:0]]  <= r_value;
                    r_link_mem[r_append[IW-1:0]] <= r_head_q;
                    r_head_mem[w_bucket]         <= r_append;
                    r_live[r_append[IW-1:0]]     <= 1'b1;
                    r_append    <= r_append + 1'b1;
                    r_count     <= r_count + 1'b1;
                    r_status    <= chm_pkg::ST_INSERTED;
                    r_vout      <= '0;
                    r_res_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_CPCLR: begin
                    r_head_mem[r_rd[IW-1:0]] <= EMPTY;
                    if (r_rd == PW'(CAPACITY-1)) begin
                        r_rd    <= '0;
                        r_wr    <= '0;
                        r_state <= S_CPREAD;
                    end else begin
                        r_rd <= r_rd + 1'b1;
                    end
                end
                S_CPREAD: begin
                    // Skip holes; read a live entry.
                    if (r_rd == PW'(CAPACITY)) begin
                        r_append <= r_wr;
                        r_count  <= r_wr;
                        r_state  <= S_CHECK;
                    end else if (r_live[r_rd[IW-1:0]]) begin
                        r_key_q <= r_key_mem[r_rd[IW-1:0]];
                        r_val_q <= r_val_mem[r_rd[IW-1:0]];
                        r_state <= S_CPWAIT;
                    end else begin
                        r_rd <= r_rd + 1'b1;
                    end
                end
                S_CPWAIT: begin
                    // The old slot is vacated here; the new one is marked next.
                    r_head_q             <= r_head_mem[w_cpbucket];
                    r_live[r_rd[IW-1:0]] <= 1'b0;
                    r_state              <= S_CPHEAD;
                end
                S_CPHEAD: begin
                    r_key_mem[r_wr[IW-1:0]]  <= r_key_q;
                    r_val_mem[r_wr[IW-1:0]]  <= r_val_q;
                    r_link_mem[r_wr[IW-1:0]] <= r_head_q;
                    r_head_mem[w_cpbucket]   <= r_wr;
                    r_live[r_wr[IW-1:0]]     <= 1'b1;
                    r_wr    <= r_wr + 1'b1;
                    r_rd    <= r_rd + 1'b1;
                    r_state <= S_CPREAD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> hdl/chained_hash_map_int_keys_top.sv
// Top level of the integer-keyed chained hash map.
// Requests enter through a queue port: drive i_req_type, i_key, i_value and
// push; a request is taken at a clock edge with push high and full low.
// Results leave through a queue port: o_status, o_value_out and
// o_live_entries hold the oldest result while empty is low, and pop takes it.
// Request codes: insert, forced insert, lookup, delete.
// A two-entry request queue feeds the engine and a two-entry result queue
// drains it, so either side may stall without losing requests.
// The engine works on one request at a time with single-ported memories and
// registered reads: the bucket head is fetched in S_HEAD and S_HEADW, each
// chain entry is read in S_ENTRY and compared in S_CHECK, a walk that misses
// ends in S_ENTRY, and an append reads the head in S_CHECK and writes in
// S_APPEND; a forced insert only appends. Each queue registers its entries,
// and the engine can take the next request while its result is taken. An
// append into an exhausted array with holes first compacts: it clears the
// bucket heads, then moves each live entry down and relinks it. After reset
// the engine clears the bucket heads in S_CLEAR; requests queue up meanwhile
// and wait for that pass. When the result queue is full, the engine holds
// its finished result and takes no new request until a result is popped.
module chained_hash_map_int_keys_top #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_req_type,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            o_status,
    output logic [VALUE_BITS-1:0] o_value_out,
    output logic [8:0]            o_live_entries
);
    `include "assert_macros.svh"

    localparam int REQ_W = 2 + KEY_BITS + VALUE_BITS;
    localparam int RES_W = chm_pkg::STATUS_W + VALUE_BITS + chm_pkg::LIVE_W;

    logic [REQ_W-1:0]      w_req_data;
    logic                  w_req_empty;
    logic                  w_eng_ready;
    logic                  w_res_valid;
    logic                  w_res_full;
    chm_pkg::t_status      w_status;
    logic [VALUE_BITS-1:0] w_vout;
    logic [chm_pkg::LIVE_W-1:0] w_live;
    logic [RES_W-1:0]      w_res_data;

    // Front queue holds accepted requests.
    chm_fifo #(.WIDTH(REQ_W), .DEPTH(2)) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({i_req_type, i_key, i_value}),
        .o_full  (full),
        .i_pop   (w_eng_ready),
        .o_empty (w_req_empty),
        .o_data  (w_req_data)
    );

    // Engine carries out one request at a time.
    chm_engine #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (!w_req_empty),
        .i_req_type  (chm_pkg::t_req'(w_req_data[REQ_W-1 -: 2])),
        .i_key       (w_req_data[VALUE_BITS +: KEY_BITS]),
        .i_value     (w_req_data[VALUE_BITS-1:0]),
        .o_req_ready (w_eng_ready),
        .o_res_valid (w_res_valid),
        .o_status    (w_status),
        .o_value     (w_vout),
        .o_live      (w_live),
        .i_res_ready (!w_res_full)
    );

    // Result queue.
    chm_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  ({w_status, w_vout, w_live}),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_data)
    );

    assign o_status       = w_res_data[RES_W-1 -: chm_pkg::STATUS_W];
    assign o_value_out    = w_res_data[chm_pkg::LIVE_W +: VALUE_BITS];
    assign o_live_entries = w_res_data[chm_pkg::LIVE_W-1:0];

    // Checks.
    `CHM_ASSERT(a_status_range, i_clk, i_rst_n,
        !empty |-> (o_status <= chm_pkg::ST_FULL), "status code out of range")
    `CHM_ASSERT(a_value_zero, i_clk, i_rst_n,
        (!empty && o_status != chm_pkg::ST_FOUND) |-> (o_value_out == '0),
        "value on non-found result")
    `CHM_ASSERT(a_live_bound, i_clk, i_rst_n,
        !empty |-> (o_live_entries <= 9'(CAPACITY)), "live count above capacity")
endmodule
